>>> src/tap_tempo_estimator_top_defines.svh
// Assertion macros for the tap tempo estimator checker
`ifndef TAP_TEMPO_ESTIMATOR_TOP_DEFINES_SVH
`define TAP_TEMPO_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define TTEMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define TTEMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ttemp_pkg.sv
// Shared constants, mode codes and control structs of the tap tempo estimator
package ttemp_pkg;

  localparam int MODE_W  = 3;
  localparam int STAMP_W = 32;
  localparam int BPM_W   = 16;
  localparam int TAPS_W  = 3;

  localparam int DEF_WINDOW_TAPS = 4;
  localparam int DEF_TIME_BITS   = 32;

  localparam logic [BPM_W-1:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [BPM_W-1:0] NO_MIN        = 16'hFFFF;

  // Event kinds carried in the mode field
  localparam logic [MODE_W-1:0] MODE_TAP     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PRESS   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLR_MIN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLR_MAX = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic apply;
    logic start_span;
    logic start_rate;
    logic commit_rate;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic finish_learn;
    logic window_full;
    logic div_busy;
    logic interval_ok;
  } status_t;

endpackage

>>> src/ttemp_datapath.sv
// Datapath: event latch, tap window, tempo registers, dividers, result word
module ttemp_datapath #(
  parameter int WINDOW_TAPS = ttemp_pkg::DEF_WINDOW_TAPS,
  parameter int TIME_BITS   = ttemp_pkg::DEF_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ttemp_pkg::cmd_t               cmd,
  output ttemp_pkg::status_t            status,
  input  logic [ttemp_pkg::MODE_W-1:0]  mode,
  input  logic [ttemp_pkg::STAMP_W-1:0] timestamp_ms,
  input  logic [ttemp_pkg::BPM_W-1:0]   new_bpm,
  output logic                          learning,
  output logic [ttemp_pkg::BPM_W-1:0]   active_bpm,
  output logic [ttemp_pkg::BPM_W-1:0]   min_bpm,
  output logic [ttemp_pkg::BPM_W-1:0]   max_bpm,
  output logic [ttemp_pkg::TAPS_W-1:0]  taps_held
);
  import ttemp_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_TAPS + 1);
  localparam int IDX_W  = $clog2(WINDOW_TAPS);
  localparam int STEP_W = $clog2(BPM_W + 1);
  localparam int GAPS   = WINDOW_TAPS - 1;
  localparam int DIGITS = (TIME_BITS + 3) / 4;
  localparam int SPAN_W = 4 * DIGITS;

  // Latched event word
  logic [MODE_W-1:0]    mode_q;
  logic [TIME_BITS-1:0] time_q;
  logic [BPM_W-1:0]     bpm_q;

  // Architectural state
  logic                 learn_flag;
  logic [CNT_W-1:0]     tap_count;
  logic [TIME_BITS-1:0] tap_times [WINDOW_TAPS];
  logic [BPM_W-1:0]     tempo_now;
  logic [BPM_W-1:0]     tempo_low;
  logic [BPM_W-1:0]     tempo_high;

  // Span divider by the gap count, one hex digit per cycle
  logic [TIME_BITS-1:0] span_diff;
  logic [SPAN_W-1:0]    span_q;
  logic [3:0]           span_rem;
  logic [STEP_W-1:0]    span_steps;
  logic [7:0]           digit_in;
  logic [3:0]           digit_q;
  logic [3:0]           digit_rem;

  // Restoring divider for the tempo
  logic [TIME_BITS-1:0] dvd;
  logic [TIME_BITS-1:0] dvs;
  logic [TIME_BITS-1:0] rem;
  logic [STEP_W-1:0]    steps;
  logic [TIME_BITS:0]   rem_sh;
  logic                 q_bit;
  logic [TIME_BITS:0]   rem_diff;

  logic                 full;
  logic [BPM_W-1:0]     set_val;
  logic [BPM_W-1:0]     note_val;
  logic                 note_en;
  logic [BPM_W-1:0]     rate_val;

  assign full     = (tap_count >= CNT_W'(WINDOW_TAPS));
  assign set_val  = (bpm_q > MS_PER_MINUTE) ? MS_PER_MINUTE : bpm_q;
  assign rate_val = dvd[BPM_W-1:0];

  assign status.finish_learn = (mode_q == MODE_PRESS) && learn_flag;
  assign status.window_full  = full;
  assign status.div_busy     = (steps != '0) || (span_steps != '0);
  assign status.interval_ok  = (span_q != '0) && (span_q <= SPAN_W'(MS_PER_MINUTE));

  // Pick the tempo that feeds the min/max tracking
  always_comb begin
    note_val = set_val;
    note_en  = 1'b0;
    if (cmd.commit_rate) begin
      note_val = rate_val;
      note_en  = 1'b1;
    end else if (cmd.apply && mode_q == MODE_SET) begin
      note_en  = 1'b1;
    end
  end

  // Capture the event word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_q <= mode;
      time_q <= TIME_BITS'(timestamp_ms);
      bpm_q  <= new_bpm;
    end
  end

  // Update learning flag, tap count and tempo registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_flag <= 1'b0;
      tap_count  <= '0;
      tempo_now  <= '0;
      tempo_low  <= NO_MIN;
      tempo_high <= '0;
    end else begin
      if (cmd.apply) begin
        case (mode_q)
          MODE_TAP: begin
            if (learn_flag && !full) tap_count <= tap_count + CNT_W'(1);
          end
          MODE_PRESS: begin
            if (learn_flag) begin
              learn_flag <= 1'b0;
            end else begin
              learn_flag <= 1'b1;
              tap_count  <= '0;
            end
          end
          MODE_SET:     tempo_now  <= set_val;
          MODE_CLR_MIN: tempo_low  <= NO_MIN;
          MODE_CLR_MAX: tempo_high <= '0;
          default: ;
        endcase
      end
      if (cmd.commit_rate) tempo_now <= rate_val;
      if (note_en && note_val != '0 && note_val < tempo_low)  tempo_low  <= note_val;
      if (note_en && note_val != '0 && note_val > tempo_high) tempo_high <= note_val;
    end
  end

  // Add a tap: fill the next slot, or drop the oldest and shift down
  always_ff @(posedge clk) begin
    if (cmd.apply && mode_q == MODE_TAP && learn_flag) begin
      if (full) begin
        for (int i = 0; i < WINDOW_TAPS - 1; i++) begin
          tap_times[i] <= tap_times[i+1];
        end
        tap_times[WINDOW_TAPS-1] <= time_q;
      end else begin
        tap_times[tap_count[IDX_W-1:0]] <= time_q;
      end
    end
  end

  // Span over the window, wrapped at the time width
  assign span_diff = tap_times[WINDOW_TAPS-1] - tap_times[0];
  assign digit_in  = {span_rem, span_q[SPAN_W-1 -: 4]};
  assign digit_rem = 4'(digit_in - 8'(digit_q) * 8'(GAPS));

  // Pick the largest multiple of the gap count that fits under the digit
  always_comb begin
    digit_q = '0;
    for (int j = 1; j < 16; j++) begin
      if (digit_in >= 8'(j * GAPS)) digit_q = 4'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_steps <= '0;
    end else if (cmd.start_span) begin
      span_steps <= STEP_W'(DIGITS);
    end else if (span_steps != '0) begin
      span_steps <= span_steps - STEP_W'(1);
    end
  end

  // Shift one quotient digit in per cycle, most significant first
  always_ff @(posedge clk) begin
    if (cmd.start_span) begin
      span_q   <= SPAN_W'(span_diff);
      span_rem <= '0;
    end else if (span_steps != '0) begin
      span_q   <= {span_q[SPAN_W-5:0], digit_q};
      span_rem <= digit_rem;
    end
  end

  // One quotient bit per cycle
  assign rem_sh   = {rem, dvd[TIME_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign q_bit    = !rem_diff[TIME_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.start_rate) begin
      steps <= STEP_W'(BPM_W);
    end else if (steps != '0) begin
      steps <= steps - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_rate) begin
      // ms per minute left-aligned, divided by the interval
      dvd <= TIME_BITS'(MS_PER_MINUTE) << (TIME_BITS - BPM_W);
      dvs <= span_q[TIME_BITS-1:0];
      rem <= '0;
    end else if (steps != '0) begin
      dvd <= {dvd[TIME_BITS-2:0], q_bit};
      rem <= q_bit ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
    end
  end

  // Snapshot the state into the result word
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      learning    <= learn_flag;
      active_bpm  <= tempo_now;
      min_bpm     <= tempo_low;
      max_bpm     <= tempo_high;
      taps_held   <= TAPS_W'(tap_count);
    end
  end

endmodule

>>> src/ttemp_ctrl.sv
// Controller: sequences one event through apply, divisions and result hand-off
module ttemp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ttemp_pkg::status_t status,
  output ttemp_pkg::cmd_t    cmd
);
  import ttemp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SPAN = 3'd2;
  localparam logic [2:0] S_RATE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.apply = 1'b1;
        if (status.finish_learn && status.window_full) begin
          cmd.start_span = 1'b1;
          state_next     = S_SPAN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SPAN: begin
        if (!status.div_busy) begin
          if (status.interval_ok) begin
            cmd.start_rate = 1'b1;
            state_next     = S_RATE;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_RATE: begin
        if (!status.div_busy) begin
          cmd.commit_rate = 1'b1;
          state_next      = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state and hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/tap_tempo_estimator_top.sv
// An accepted word is latched, applied to the state, then copied into the result word,
// which waits while an earlier result is held. Leaving learning with a full window adds
// a hex-digit divide of the span by the gap count, then, if the interval is in range,
// a 16-step divide into 60000. Throughput: one word in flight, the next accepted the
// cycle after its result is loaded.
// Synchronous rst: not learning, no taps, tempo 0, minimum 65535, maximum 0.
module tap_tempo_estimator_top #(
  parameter int WINDOW_TAPS = ttemp_pkg::DEF_WINDOW_TAPS,
  parameter int TIME_BITS   = ttemp_pkg::DEF_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ttemp_pkg::MODE_W-1:0]  mode,
  input  logic [ttemp_pkg::STAMP_W-1:0] timestamp_ms,
  input  logic [ttemp_pkg::BPM_W-1:0]   new_bpm,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          learning,
  output logic [ttemp_pkg::BPM_W-1:0]   active_bpm,
  output logic [ttemp_pkg::BPM_W-1:0]   min_bpm,
  output logic [ttemp_pkg::BPM_W-1:0]   max_bpm,
  output logic [ttemp_pkg::TAPS_W-1:0]  taps_held
);
  import ttemp_pkg::*;

  cmd_t    cmd;
  status_t status;

  ttemp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ttemp_datapath #(
    .WINDOW_TAPS (WINDOW_TAPS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .mode         (mode),
    .timestamp_ms (timestamp_ms),
    .new_bpm      (new_bpm),
    .learning     (learning),
    .active_bpm   (active_bpm),
    .min_bpm      (min_bpm),
    .max_bpm      (max_bpm),
    .taps_held    (taps_held)
  );

endmodule

>>> src/ttemp_checker.sv
// Port-level checks of the tap tempo estimator, bound to the top level
`include "tap_tempo_estimator_top_defines.svh"

module ttemp_checker #(
  parameter int WINDOW_TAPS = ttemp_pkg::DEF_WINDOW_TAPS
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ttemp_pkg::BPM_W-1:0]  active_bpm,
  input logic [ttemp_pkg::TAPS_W-1:0] taps_held
);
  import ttemp_pkg::*;

  // Stalled result word holds
  `TTEMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(active_bpm), "result word changed while stalled")

  // One word in flight: no accept right after an accept
  `TTEMP_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input ready right after an accepted word")

  // Tempo never exceeds one per millisecond
  `TTEMP_ASSERT_NOW(a_bpm_range, out_valid, active_bpm <= MS_PER_MINUTE, "current tempo above 60000")

  // Window count never exceeds the window size
  `TTEMP_ASSERT_NOW(a_taps_range, out_valid, 32'(taps_held) <= 32'(WINDOW_TAPS), "tap count beyond window")

endmodule

bind tap_tempo_estimator_top ttemp_checker #(
  .WINDOW_TAPS (WINDOW_TAPS)
) u_ttemp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .active_bpm  (active_bpm),
  .taps_held   (taps_held)
);

>>> dv/tap_tempo_estimator_top_test.sv
// Self-checking testbench for the tap tempo estimator: event words in, tempo reports out
module tap_tempo_estimator_top_test;
  import ttemp_pkg::*;

  localparam int WIN       = DEF_WINDOW_TAPS;
  localparam int CYCLE_CAP = 400000;
  localparam int DRAIN_CYC = 60;
  localparam int HOLD_AT   = 300;
  localparam int HOLD_LEN  = 400;
  localparam int N_WORDS   = 1100;

  typedef struct packed {
    logic               learning;
    logic [BPM_W-1:0]   active_bpm;
    logic [BPM_W-1:0]   min_bpm;
    logic [BPM_W-1:0]   max_bpm;
    logic [TAPS_W-1:0]  taps_held;
  } tempo_report_t;

  // Tracks the estimator state and the reports still owed by the block
  class tempo_tracker;
    logic               learn_on;
    logic [STAMP_W-1:0] tap_ring [WIN];
    int unsigned        taps_in;
    logic [BPM_W-1:0]   tempo_now;
    logic [BPM_W-1:0]   tempo_lo;
    logic [BPM_W-1:0]   tempo_hi;
    tempo_report_t      reports_due [$];
    int unsigned        errors;

    function new();
      learn_on  = 1'b0;
      taps_in   = 0;
      tempo_now = '0;
      tempo_lo  = NO_MIN;
      tempo_hi  = '0;
      errors    = 0;
      foreach (tap_ring[i]) tap_ring[i] = '0;
    endfunction

    function int pending();
      return reports_due.size();
    endfunction

    function void widen_range(logic [BPM_W-1:0] bpm);
      if (bpm != '0 && bpm < tempo_lo) tempo_lo = bpm;
      if (bpm != '0 && bpm > tempo_hi) tempo_hi = bpm;
    endfunction

    // Mean interval over the window, then 60000 / interval
    function void close_window();
      logic [STAMP_W-1:0] span;
      logic [STAMP_W-1:0] gap;
      logic [STAMP_W-1:0] rate;
      learn_on = 1'b0;
      if (taps_in < WIN) return;
      span = tap_ring[WIN-1] - tap_ring[0];
      gap  = span / STAMP_W'(WIN - 1);
      if (gap == '0) return;
      rate = STAMP_W'(MS_PER_MINUTE) / gap;
      if (rate == '0) return;
      widen_range(rate[BPM_W-1:0]);
      tempo_now = rate[BPM_W-1:0];
    endfunction

    // Advance the state by one accepted event word and queue its report
    function void note_word(logic [MODE_W-1:0] m, logic [STAMP_W-1:0] ts,
                            logic [BPM_W-1:0] v);
      tempo_report_t r;
      case (m)
        MODE_TAP: begin
          if (learn_on) begin
            if (taps_in >= WIN) begin
              for (int i = 0; i < WIN - 1; i++) tap_ring[i] = tap_ring[i+1];
              tap_ring[WIN-1] = ts;
            end else begin
              tap_ring[taps_in] = ts;
              taps_in++;
            end
          end
        end
        MODE_PRESS: begin
          if (learn_on) begin
            close_window();
          end else begin
            taps_in  = 0;
            learn_on = 1'b1;
          end
        end
        MODE_SET: begin
          if (v > MS_PER_MINUTE) v = MS_PER_MINUTE;
          tempo_now = v;
          widen_range(v);
        end
        MODE_CLR_MIN: tempo_lo = NO_MIN;
        MODE_CLR_MAX: tempo_hi = '0;
        default: ;
      endcase
      r.learning    = learn_on;
      r.active_bpm  = tempo_now;
      r.min_bpm     = tempo_lo;
      r.max_bpm     = tempo_hi;
      r.taps_held   = TAPS_W'(taps_in);
      reports_due.push_back(r);
    endfunction

    // Compare one accepted report with the oldest one owed
    function void check_word(tempo_report_t got);
      tempo_report_t want;
      logic bad;
      if (reports_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected report: learn=%0b cur=%0d min=%0d max=%0d taps=%0d",
                   got.learning, got.active_bpm, got.min_bpm, got.max_bpm,
                   got.taps_held);
        return;
      end
      want = reports_due.pop_front();
      bad = (got.learning !== want.learning) || (got.active_bpm !== want.active_bpm) ||
            (got.min_bpm !== want.min_bpm) || (got.max_bpm !== want.max_bpm) ||
            (got.taps_held !== want.taps_held);
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("report differs: exp learn=%0b cur=%0d min=%0d max=%0d taps=%0d, got learn=%0b cur=%0d min=%0d max=%0d taps=%0d",
                   want.learning, want.active_bpm, want.min_bpm, want.max_bpm,
                   want.taps_held, got.learning, got.active_bpm, got.min_bpm,
                   got.max_bpm, got.taps_held);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [MODE_W-1:0]   mode;
  logic [STAMP_W-1:0]  timestamp_ms;
  logic [BPM_W-1:0]    new_bpm;
  logic                out_valid;
  logic                out_ready;
  logic                learning;
  logic [BPM_W-1:0]    active_bpm;
  logic [BPM_W-1:0]    min_bpm;
  logic [BPM_W-1:0]    max_bpm;
  logic [TAPS_W-1:0]   taps_held;

  tempo_tracker book;
  logic         calm;
  int unsigned  words_sent;
  int unsigned  reports_seen;
  int unsigned  hold_left;
  logic         hold_done;
  int unsigned  cycles;

  tap_tempo_estimator_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .timestamp_ms (timestamp_ms),
    .new_bpm      (new_bpm),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .learning     (learning),
    .active_bpm   (active_bpm),
    .min_bpm      (min_bpm),
    .max_bpm      (max_bpm),
    .taps_held    (taps_held)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("tap_tempo_estimator_top: mismatch");
      $finish;
    end
  end

  // Take reports, with random stalls and one long hold-off
  initial begin
    reports_seen = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
  end
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      book.check_word('{learning, active_bpm, min_bpm, max_bpm, taps_held});
      reports_seen++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && reports_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 12);
    end
  end

  // Offer one event word and hold it until accepted
  task automatic offer_word(logic [MODE_W-1:0] m, logic [STAMP_W-1:0] ts,
                            logic [BPM_W-1:0] v);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    timestamp_ms <= ts;
    new_bpm      <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_word(m, ts, v);
    words_sent++;
  endtask

  // Filler word: any mode, random time and tempo
  task automatic noise_word();
    logic [BPM_W-1:0] v;
    v = ($urandom_range(0, 1) == 0) ? BPM_W'($urandom_range(0, 65535))
                                    : BPM_W'($urandom_range(0, 400));
    offer_word(MODE_W'($urandom_range(0, 7)), $urandom(), v);
  endtask

  // Press, a run of taps with a chosen spacing and occasional filler, usually press again
  task automatic learn_sequence();
    int unsigned      n_taps;
    int unsigned      step;
    int unsigned      jit;
    int unsigned      kind;
    logic [STAMP_W-1:0] t;
    n_taps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 7);
    kind   = $urandom_range(0, 9);
    if (kind == 0) begin
      step = $urandom_range(0, 2);
      jit  = 1;
    end else if (kind == 1) begin
      step = $urandom_range(60001, 400000);
      jit  = 1000;
    end else begin
      step = $urandom_range(1, 3000);
      jit  = 30;
    end
    t = $urandom();
    offer_word(MODE_PRESS, $urandom(), BPM_W'($urandom()));
    for (int i = 0; i < n_taps; i++) begin
      if ($urandom_range(0, 19) == 0) noise_word();
      offer_word(MODE_TAP, t, BPM_W'($urandom()));
      t = t + step + $urandom_range(0, jit);
    end
    // Leave some windows open so the next press closes them instead
    if ($urandom_range(0, 9) != 0)
      offer_word(MODE_PRESS, t, BPM_W'($urandom()));
  endtask

  initial begin
    logic [STAMP_W-1:0] t0;
    book         = new();
    calm         = 1'b0;
    words_sent   = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    out_ready    = 1'b0;
    mode         = MODE_TAP;
    timestamp_ms = '0;
    new_bpm      = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored words, set extremes, clears
    offer_word(MODE_TAP, 32'hFFFF_FFFF, 16'hFFFF);
    offer_word(3'd5, 32'h0, 16'h0);
    offer_word(3'd7, 32'hAAAA_5555, 16'h5A5A);
    offer_word(MODE_SET, 32'h0, 16'hFFFF);
    offer_word(MODE_SET, 32'h0, 16'd0);
    offer_word(MODE_SET, 32'h0, 16'd1);
    offer_word(MODE_CLR_MIN, 32'h0, 16'd0);
    offer_word(MODE_CLR_MAX, 32'h0, 16'd0);

    // Directed: full window across the time wrap, then one tap more
    t0 = 32'hFFFF_FE00;
    offer_word(MODE_PRESS, 32'h0, 16'd0);
    offer_word(MODE_TAP, t0, 16'd0);
    offer_word(MODE_TAP, t0 + 400, 16'd0);
    offer_word(MODE_TAP, t0 + 800, 16'd0);
    offer_word(MODE_TAP, t0 + 1200, 16'd0);
    offer_word(MODE_TAP, t0 + 1700, 16'd0);
    offer_word(MODE_PRESS, 32'h0, 16'd0);

    // Directed: short window leaves tempo alone
    offer_word(MODE_PRESS, 32'h0, 16'd0);
    offer_word(MODE_TAP, 32'd100, 16'd0);
    offer_word(MODE_PRESS, 32'h0, 16'd0);

    // Directed: zero interval leaves tempo alone
    offer_word(MODE_PRESS, 32'h0, 16'd0);
    offer_word(MODE_TAP, 32'd7, 16'd0);
    offer_word(MODE_TAP, 32'd7, 16'd0);
    offer_word(MODE_TAP, 32'd8, 16'd0);
    offer_word(MODE_TAP, 32'd9, 16'd0);
    offer_word(MODE_PRESS, 32'h0, 16'd0);

    // Random: mostly learning runs, some filler
    while (words_sent < N_WORDS) begin
      calm <= (words_sent >= 500 && words_sent < 700);
      if ($urandom_range(0, 99) < 70) learn_sequence();
      else noise_word();
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // Drain, then allow a slow divide to show any stray report
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (book.errors == 0)
      $display("tap_tempo_estimator_top: match");
    else
      $display("tap_tempo_estimator_top: mismatch");
    $finish;
  end

endmodule

>>> tap_tempo_estimator_top.f
+incdir+src
src/ttemp_pkg.sv
src/ttemp_datapath.sv
src/ttemp_ctrl.sv
src/tap_tempo_estimator_top.sv
src/ttemp_checker.sv
dv/tap_tempo_estimator_top_test.sv
